// ===== rtl/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg
// Types and constants shared by the keyframe track sampler modules.
// ----------------------------------------------------------------------------
package kts_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int IDX_W     = $clog2(MAX_KEYS);
	localparam int COUNT_W   = IDX_W + 1;
	localparam int DIV_STEPS = 16;
	localparam int FRAC_W    = DIV_STEPS + 1;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << DIV_STEPS;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] time_value;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               used_fallback;
		logic [5:0]         segment_left;
	} res_t;

	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} key_t;

	typedef struct packed {
		logic                 valid;
		logic [31:0]          rem;
		logic [DIV_STEPS-1:0] quot;
	} div_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_LEFT,
		S_RIGHT,
		S_DIV,
		S_MUL,
		S_SUM
	} state_t;

endpackage

// ===== rtl/keyframe_track_sampler.sv =====
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe track with step or linear sampling of three Q16.16 components.
// ----------------------------------------------------------------------------
// Clear and append beats give no result and busy stays low. A query on an
// empty, unordered or overflowed track returns the fallback in the next
// cycle. Otherwise a binary search over the key memory passes through the
// search and compare states for each probe (up to seven probes for 64 keys,
// one read port), followed by one or two key reads; a step or end-of-track
// sample ends there, a linear sample runs through the 16-cell division row
// (skipped outside the segment) and a multiply and add stage, and the result
// follows in the next cycle. The result is shown for exactly one cycle with
// done high and cannot be held off; start is taken only while busy is low.
module keyframe_track_sampler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kts_pkg::cmd_t item,
	output logic          done,
	output kts_pkg::res_t result,
	input  logic          interp_we,
	input  logic          interp_wdata
);
	import kts_pkg::*;

	state_t            state_q, state_d;
	key_t              mem [MAX_KEYS];
	key_t              rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [COUNT_W-1:0] key_count_q, lo_q, hi_q;
	logic [IDX_W-1:0]  mid_q, sel_q;
	logic              order_ok_q, overflowed_q, interp_mode_q, interp_q;
	logic signed [31:0] last_time_q, t_q;
	key_t              left_q, right_q;
	logic [31:0]       span_q;
	logic [FRAC_W-1:0] frac_q;
	logic signed [50:0] prod_x_q, prod_y_q, prod_z_q;
	res_t              result_q;
	logic              done_q;
	logic              accept, fallback;
	logic [IDX_W-1:0]  mid;
	logic signed [32:0] span, off;
	logic [31:0]       div_divisor;
	div_beat_t         div_in, div_out;

	assign accept   = start && state_q == S_IDLE;
	assign fallback = key_count_q == '0 || !order_ok_q || overflowed_q;
	assign mid      = IDX_W'((COUNT_W+1)'(lo_q) + (COUNT_W+1)'(hi_q) >> 1);
	assign span     = {rd_q.t[31], rd_q.t} - {left_q.t[31], left_q.t};
	assign off      = {t_q[31], t_q} - {left_q.t[31], left_q.t};

	always_comb begin
		state_d = state_q;
		rd_addr = mid;
		unique case (state_q)
			S_IDLE: begin
				if (accept && item.opcode == OP_QUERY && !fallback) begin
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					state_d = S_CMP;
				end else begin
					state_d = S_LEFT;
					if (lo_q == '0) begin
						rd_addr = '0;
					end else if (lo_q >= key_count_q) begin
						rd_addr = IDX_W'(key_count_q - 1'b1);
					end else begin
						rd_addr = IDX_W'(lo_q - 1'b1);
					end
				end
			end
			S_CMP:   state_d = S_SRCH;
			S_LEFT: begin
				rd_addr = sel_q + 1'b1;
				state_d = interp_q ? S_RIGHT : S_IDLE;
			end
			S_RIGHT: begin
				if (span > 0 && off >= 0 && off < span) begin
					state_d = S_DIV;
				end else begin
					state_d = S_MUL;
				end
			end
			S_DIV: begin
				if (div_out.valid) begin
					state_d = S_MUL;
				end
			end
			S_MUL:   state_d = S_SUM;
			S_SUM:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			key_count_q   <= '0;
			order_ok_q    <= 1'b1;
			overflowed_q  <= 1'b0;
			interp_mode_q <= 1'b1;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && item.opcode == OP_QUERY && fallback)
				|| (state_q == S_LEFT && !interp_q) || state_q == S_SUM;
			if (interp_we) begin
				interp_mode_q <= interp_wdata;
			end
			if (accept && item.opcode == OP_CLEAR) begin
				key_count_q  <= '0;
				order_ok_q   <= 1'b1;
				overflowed_q <= 1'b0;
			end else if (accept && item.opcode == OP_APPEND) begin
				if (key_count_q >= COUNT_W'(MAX_KEYS)) begin
					overflowed_q <= 1'b1;
				end else begin
					key_count_q <= key_count_q + 1'b1;
					if (key_count_q != '0 && item.time_value < last_time_q) begin
						order_ok_q <= 1'b0;
					end
				end
			end
		end
	end

	// key memory
	always_ff @(posedge clk) begin
		if (accept && item.opcode == OP_APPEND && key_count_q < COUNT_W'(MAX_KEYS)) begin
			mem[key_count_q[IDX_W-1:0]] <= '{item.time_value, item.value_x,
				item.value_y, item.value_z};
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		div_in.valid = state_q == S_RIGHT && state_d == S_DIV;
		div_in.rem   = off[31:0];
		div_in.quot  = '0;
	end

	// first cell sees the span before it is registered
	assign div_divisor = (state_q == S_RIGHT) ? span[31:0] : span_q;

	kts_div_chain u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.divisor (div_divisor),
		.din     (div_in),
		.dout    (div_out)
	);

	always_ff @(posedge clk) begin
		if (accept && item.opcode == OP_APPEND) begin
			last_time_q <= item.time_value;
		end
		if (accept && item.opcode == OP_QUERY) begin
			t_q  <= item.time_value;
			lo_q <= '0;
			hi_q <= key_count_q;
			result_q <= '{item.value_x, item.value_y, item.value_z, 1'b1, 6'd0};
		end
		unique case (state_q)
			S_SRCH: begin
				mid_q <= mid;
				if (lo_q >= hi_q) begin
					sel_q    <= rd_addr;
					interp_q <= interp_mode_q && lo_q != '0 && lo_q < key_count_q;
				end
			end
			S_CMP: begin
				if (rd_q.t > t_q) begin
					hi_q <= COUNT_W'(mid_q);
				end else begin
					lo_q <= COUNT_W'(mid_q) + 1'b1;
				end
			end
			S_LEFT: begin
				left_q <= rd_q;
				if (!interp_q) begin
					result_q <= '{rd_q.x, rd_q.y, rd_q.z, 1'b0, 6'(sel_q)};
				end
			end
			S_RIGHT: begin
				right_q <= rd_q;
				span_q  <= span[31:0];
				if (span > 0 && off >= span) begin
					frac_q <= FRAC_ONE;
				end else begin
					frac_q <= '0;
				end
			end
			S_DIV: begin
				if (div_out.valid) begin
					frac_q <= FRAC_W'(div_out.quot);
				end
			end
			S_MUL: begin
				prod_x_q <= 51'($signed({right_q.x[31], right_q.x} - {left_q.x[31], left_q.x})
					* $signed({1'b0, frac_q}));
				prod_y_q <= 51'($signed({right_q.y[31], right_q.y} - {left_q.y[31], left_q.y})
					* $signed({1'b0, frac_q}));
				prod_z_q <= 51'($signed({right_q.z[31], right_q.z} - {left_q.z[31], left_q.z})
					* $signed({1'b0, frac_q}));
			end
			S_SUM: begin
				result_q <= '{left_q.x + prod_x_q[47:16], left_q.y + prod_y_q[47:16],
					left_q.z + prod_z_q[47:16], 1'b0, 6'(sel_q)};
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) && !$past(busy)) || $past(state_q == S_LEFT)
			|| $past(state_q == S_SUM))
		else $error("result beat without a query");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= COUNT_W'(MAX_KEYS))
		else $error("key count beyond capacity");
	a_fallback_seg: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.used_fallback |-> result.segment_left == '0)
		else $error("fallback beat with nonzero segment");
	a_div_interp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> interp_q)
		else $error("division started in step mode");
`endif

endmodule

// ===== rtl/kts_div_cell.sv =====
// ----------------------------------------------------------------------------
// kts_div_cell
// One restoring division step: shifts the remainder, subtracts the divisor
// when it fits and appends one quotient bit, registered toward the next cell.
// ----------------------------------------------------------------------------
module kts_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       divisor,
	input  kts_pkg::div_beat_t din,
	output kts_pkg::div_beat_t dout
);
	import kts_pkg::*;

	logic [32:0]          shifted;
	logic                 fits;
	div_beat_t            nxt;
	logic                 valid_q;
	logic [31:0]          rem_q;
	logic [DIV_STEPS-1:0] quot_q;

	always_comb begin
		shifted   = {din.rem, 1'b0};
		fits      = shifted >= {1'b0, divisor};
		nxt.valid = din.valid;
		nxt.rem   = fits ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];
		nxt.quot  = {din.quot[DIV_STEPS-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= nxt.rem;
		quot_q <= nxt.quot;
	end

	assign dout = '{valid_q, rem_q, quot_q};

endmodule

// ===== rtl/kts_div_chain.sv =====
// ----------------------------------------------------------------------------
// kts_div_chain
// Row of division cells giving floor(rem * 2^16 / divisor) for rem < divisor.
// ----------------------------------------------------------------------------
module kts_div_chain (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        divisor,
	input  kts_pkg::div_beat_t din,
	output kts_pkg::div_beat_t dout
);
	import kts_pkg::*;

	div_beat_t link [DIV_STEPS+1];

	assign link[0] = din;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		kts_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.divisor (divisor),
			.din     (link[i]),
			.dout    (link[i+1])
		);
	end

	assign dout = link[DIV_STEPS];

`ifndef ASSERT_OFF
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> dout.rem < divisor)
		else $error("division remainder not below divisor");
	a_valid_delay: assert property (@(posedge clk) disable iff (!arst_n)
		link[1].valid |-> $past(din.valid))
		else $error("first cell valid without input beat");
	a_first_bit: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.rem < divisor |=> link[1].rem < divisor)
		else $error("cell broke remainder bound");
`endif

endmodule
